FILE: rtl/i2cms_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
package i2cms_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;
    localparam logic [1:0] KIND_FETCH = 2'd3;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_PING  = 2'd2;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_NACK  = 3'd2;
    localparam logic [2:0] ACT_ACK   = 3'd3;
    localparam logic [2:0] ACT_STOP  = 3'd4;

    localparam logic [7:0] BUS_START      = 8'h08;
    localparam logic [7:0] BUS_RESTART    = 8'h10;
    localparam logic [7:0] BUS_ADDR_W_ACK = 8'h18;
    localparam logic [7:0] BUS_DATA_TX    = 8'h28;
    localparam logic [7:0] BUS_ADDR_R_ACK = 8'h40;
    localparam logic [7:0] BUS_DATA_ACK   = 8'h50;
    localparam logic [7:0] BUS_DATA_NACK  = 8'h58;

    localparam logic [7:0] STATUS_OK = 8'h00;

    typedef struct packed {
        logic [7:0] bus_code;
        logic [7:0] data_byte;
        logic [4:0] buffer_index;
        logic [5:0] length;
        logic [7:0] register_addr;
        logic [6:0] device_id;
        logic [1:0] op;
        logic [1:0] kind;
    } item_t;

    typedef struct packed {
        logic       last;
        logic [7:0] status_code;
        logic       error;
        logic       busy_res;
        logic [7:0] read_byte;
        logic [7:0] tx_byte;
        logic [2:0] action;
    } result_t;

endpackage

FILE: rtl/i2cms_store.sv
// Payload byte store with one write port and a registered read port.
module i2cms_store #(
    parameter int BUFFER_DEPTH = 32,
    parameter int AW           = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A write to the read address in the same cycle as the read is forwarded to the read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/i2cms_fsm.sv
// Transaction state and the per-request decision logic.
module i2cms_fsm #(
    parameter int BUFFER_DEPTH = 32,
    parameter int AW           = 5,
    parameter int POS_W        = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                proc,
    input  i2cms_pkg::item_t    item,
    input  logic [7:0]          rd_data,
    output i2cms_pkg::result_t  res0,
    output i2cms_pkg::result_t  res1,
    output logic                two,
    output logic                we,
    output logic [AW-1:0]       waddr,
    output logic [7:0]          wdata,
    output logic [POS_W-1:0]    pos_after
);
    import i2cms_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_TX, PH_RX} phase_t;

    phase_t           phase_reg, phase_next;
    logic             rp_reg, rp_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] tlen_reg, tlen_next;
    logic [POS_W-1:0] rlen_reg, rlen_next;
    logic [7:0]       status_reg, status_next;
    logic             err_reg, err_next;
    logic [6:0]       target_reg, target_next;
    logic [7:0]       regb_reg, regb_next;

    logic [POS_W-1:0] pos_plus;
    logic [POS_W-1:0] pc;
    logic [POS_W-1:0] pos_rx;
    logic [POS_W-1:0] len_sat;
    logic             idx_ok;
    logic             pos_in_buf;
    logic             finish;

    function automatic logic [7:0] tx_at(input phase_t ph, input logic [POS_W-1:0] p,
                                         input logic [6:0] tid, input logic [7:0] rb,
                                         input logic [7:0] md);
        logic [7:0] v;
        if (ph == PH_RX)
        begin
            v = {tid, 1'b1};
        end
        else if (p == '0)
        begin
            v = {tid, 1'b0};
        end
        else if (p == POS_W'(1))
        begin
            v = rb;
        end
        else if (32'(p) < 32'(BUFFER_DEPTH) + 32'd2)
        begin
            v = md;
        end
        else
        begin
            v = 8'h00;
        end
        return v;
    endfunction

    assign pos_plus   = pos_reg + POS_W'(1);
    assign pc         = (item.bus_code == BUS_ADDR_W_ACK) ? pos_plus : pos_reg;
    assign idx_ok     = 32'(item.buffer_index) < 32'(BUFFER_DEPTH);
    assign pos_in_buf = 32'(pos_reg) < 32'(BUFFER_DEPTH);
    assign pos_rx     = (item.bus_code == BUS_DATA_ACK && pos_in_buf) ? pos_plus : pos_reg;
    assign len_sat    = (32'(item.length) > 32'(BUFFER_DEPTH)) ? POS_W'(BUFFER_DEPTH)
                                                              : POS_W'(item.length);

    always_comb
    begin
        phase_next  = phase_reg;
        rp_next     = rp_reg;
        pos_next    = pos_reg;
        tlen_next   = tlen_reg;
        rlen_next   = rlen_reg;
        status_next = status_reg;
        err_next    = err_reg;
        target_next = target_reg;
        regb_next   = regb_reg;
        res0        = '0;
        res1        = '0;
        two         = 1'b0;
        we          = 1'b0;
        waddr       = AW'(item.buffer_index);
        wdata       = item.data_byte;
        finish      = 1'b0;
        res0.action = ACT_NONE;

        unique case (item.kind)
            KIND_LOAD:
            begin
                we = (phase_reg == PH_IDLE) && idx_ok;
            end
            KIND_FETCH:
            begin
                res0.read_byte = idx_ok ? rd_data : 8'h00;
            end
            KIND_START:
            begin
                if (phase_reg == PH_IDLE && item.op <= OP_PING)
                begin
                    target_next = item.device_id;
                    regb_next   = item.register_addr;
                    pos_next    = '0;
                    phase_next  = PH_TX;
                    rp_next     = 1'b0;
                    res0.action = ACT_START;
                    case (item.op)
                        OP_WRITE: tlen_next = len_sat + POS_W'(2);
                        OP_READ:
                        begin
                            tlen_next = POS_W'(2);
                            rlen_next = len_sat;
                            rp_next   = 1'b1;
                        end
                        default:  tlen_next = POS_W'(1);
                    endcase
                end
            end
            KIND_EVENT:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (item.bus_code == BUS_START || item.bus_code == BUS_RESTART)
                    begin
                        pos_next     = '0;
                        status_next  = STATUS_OK;
                        err_next     = 1'b0;
                        res0.action  = ACT_NACK;
                        res0.tx_byte = tx_at(phase_reg, '0, target_reg, regb_reg, rd_data);
                    end
                    else if (phase_reg == PH_TX && (item.bus_code == BUS_ADDR_W_ACK ||
                                                    item.bus_code == BUS_DATA_TX))
                    begin
                        if (pc < tlen_reg)
                        begin
                            pos_next     = pc + POS_W'(1);
                            res0.action  = ACT_NACK;
                            res0.tx_byte = tx_at(phase_reg, pc, target_reg, regb_reg, rd_data);
                        end
                        else
                        begin
                            pos_next    = pc;
                            status_next = STATUS_OK;
                            err_next    = 1'b0;
                            finish      = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_RX && (item.bus_code == BUS_ADDR_R_ACK ||
                                                    item.bus_code == BUS_DATA_ACK))
                    begin
                        if (item.bus_code == BUS_DATA_ACK)
                        begin
                            we = pos_in_buf;
                        end
                        waddr    = AW'(pos_reg);
                        pos_next = pos_rx;
                        if (({1'b0, pos_rx} + (POS_W+1)'(1) < {1'b0, rlen_reg}) &&
                            rlen_reg != '0)
                        begin
                            res0.action = ACT_ACK;
                        end
                        else
                        begin
                            res0.action = ACT_NACK;
                        end
                    end
                    else if (phase_reg == PH_RX && item.bus_code == BUS_DATA_NACK)
                    begin
                        we          = pos_in_buf;
                        waddr       = AW'(pos_reg);
                        status_next = STATUS_OK;
                        err_next    = 1'b0;
                        finish      = 1'b1;
                    end
                    else
                    begin
                        status_next = item.bus_code;
                        err_next    = 1'b1;
                        finish      = 1'b1;
                    end
                end
            end
        endcase

        // A stop ends the phase; a pending read turns around into receive mode.
        if (finish)
        begin
            res0.action = ACT_STOP;
            if (rp_reg)
            begin
                rp_next     = 1'b0;
                phase_next  = PH_RX;
                pos_next    = '0;
                tlen_next   = rlen_reg;
                two         = 1'b1;
                res1.action = ACT_START;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end

        res0.busy_res    = (phase_next != PH_IDLE);
        res0.error       = err_next;
        res0.status_code = status_next;
        res0.last        = !two;
        res1.busy_res    = (phase_next != PH_IDLE);
        res1.error       = err_next;
        res1.status_code = status_next;
        res1.last        = 1'b1;
        we               = we && proc;
    end

    assign pos_after = proc ? pos_next : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            rp_reg     <= 1'b0;
            pos_reg    <= '0;
            tlen_reg   <= '0;
            rlen_reg   <= '0;
            status_reg <= STATUS_OK;
            err_reg    <= 1'b0;
            target_reg <= '0;
            regb_reg   <= '0;
        end
        else if (proc)
        begin
            phase_reg  <= phase_next;
            rp_reg     <= rp_next;
            pos_reg    <= pos_next;
            tlen_reg   <= tlen_next;
            rlen_reg   <= rlen_next;
            status_reg <= status_next;
            err_reg    <= err_next;
            target_reg <= target_next;
            regb_reg   <= regb_next;
        end
    end

    a_pending_only_in_tx: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg |-> (phase_reg == PH_TX))
        else $error("read turnaround pending outside the transmit phase");

    a_two_is_turnaround: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && two) |-> (res0.action == ACT_STOP && res1.action == ACT_START &&
                           item.kind == KIND_EVENT))
        else $error("two results from something other than a read turnaround");

    a_turnaround_enters_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && two) |=> (phase_reg == PH_RX && pos_reg == '0 && !rp_reg))
        else $error("read turnaround did not enter receive mode");

endmodule

FILE: rtl/i2cms_out_fifo.sv
// Four-entry result queue that takes one or two results per cycle.
module i2cms_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                two,
    input  i2cms_pkg::result_t  res0,
    input  i2cms_pkg::result_t  res1,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cms_pkg::result_t  head
);
    import i2cms_pkg::*;

    localparam int DEPTH = 4;

    result_t    mem [DEPTH];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] count_reg, count_next;
    logic [2:0] n_push;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign n_push  = push ? (two ? 3'd2 : 3'd1) : 3'd0;
    assign m_valid = (count_reg != 3'd0);
    assign head    = mem[rptr_reg];
    // Room for a full turnaround is judged on registered state only.
    assign room    = (count_reg <= 3'(DEPTH - 2));

    assign wptr_next  = wptr_reg + n_push[1:0];
    assign rptr_next  = rptr_reg + {1'b0, pop};
    assign count_next = count_reg + n_push - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= res0;
        end
        if (push && two)
        begin
            mem[wptr_reg + 2'd1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg <= 3'(DEPTH - 2)))
        else $error("result pushed without room for it");

    a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 3'(DEPTH)) && (count_reg[1:0] == (wptr_reg - rptr_reg)))
        else $error("result queue count out of step with its pointers");

endmodule

FILE: rtl/i2c_master_transaction_sequencer.sv
// Top level of the I2C master transaction sequencer.
//
// Requests enter on the s_ channel: s_tuser carries the request kind (load byte,
// start transaction, bus event, fetch byte) and s_tdata the remaining fields.
// Every request yields one result on the m_ channel, except a read whose
// address phase ends, which yields a stop and then a start; m_tlast marks the
// final result of a request.
// A request is held in an input register, decided by single-pass logic and
// written into a four-entry result queue, from whose head its first result
// is offered on the m_ channel.
// One request is taken every cycle while the queue holds two results or fewer;
// the queue depth sets that figure.
// The byte store read for a fetch or a transmit byte is issued as the request
// is taken, so it is ready when the request is decided.
// Reset returns the sequencer to idle with a clear status and empties the
// queue; the byte store keeps no reset. When the receiver stalls, the queue
// fills, and s_tready falls once it holds three or more results while a
// request waits in the input register.
module i2c_master_transaction_sequencer #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op, device_id, register_addr, length, buffer_index, data_byte, bus_code, zero pad
    input  logic [47:0] s_tdata,
    // kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // action, tx_byte, read_byte, busy_res, error, status_code, zero pad
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    import i2cms_pkg::*;

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int POS_W = $clog2(BUFFER_DEPTH + 4);

    item_t            in_item_reg;
    logic             in_valid_reg, in_valid_next;
    item_t            s_item;
    logic             s_take;
    logic             proc;
    logic             room;
    result_t          res0, res1, head;
    logic             two;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [7:0]       wdata;
    logic [7:0]       rd_data;
    logic [POS_W-1:0] pos_after;
    logic [POS_W-1:0] pred_pos;
    logic [AW-1:0]    raddr;

    assign s_item.kind          = s_tuser;
    assign s_item.op            = s_tdata[1:0];
    assign s_item.device_id     = s_tdata[8:2];
    assign s_item.register_addr = s_tdata[16:9];
    assign s_item.length        = s_tdata[22:17];
    assign s_item.buffer_index  = s_tdata[27:23];
    assign s_item.data_byte     = s_tdata[35:28];
    assign s_item.bus_code      = s_tdata[43:36];

    assign proc          = in_valid_reg && room;
    assign s_tready      = !in_valid_reg || room;
    assign s_take        = s_tvalid && s_tready;
    assign in_valid_next = s_take || (in_valid_reg && !proc);

    // The transmit byte is fetched for the position the request will see.
    assign pred_pos = (s_item.bus_code == BUS_ADDR_W_ACK) ? pos_after + POS_W'(1) : pos_after;
    assign raddr    = (s_item.kind == KIND_FETCH) ? AW'(s_item.buffer_index)
                                                  : AW'(pred_pos - POS_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_item_reg <= '0;
        end
        else if (s_take)
        begin
            in_item_reg <= s_item;
        end
    end

    i2cms_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (s_take),
        .raddr (raddr),
        .rdata (rd_data)
    );

    i2cms_fsm #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW),
        .POS_W        (POS_W)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc      (proc),
        .item      (in_item_reg),
        .rd_data   (rd_data),
        .res0      (res0),
        .res1      (res1),
        .two       (two),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .pos_after (pos_after)
    );

    i2cms_out_fifo u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (proc),
        .two     (two),
        .res0    (res0),
        .res1    (res1),
        .room    (room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .head    (head)
    );

    assign m_tdata = {3'b000, head.status_code, head.error, head.busy_res,
                      head.read_byte, head.tx_byte, head.action};
    assign m_tlast = head.last;

endmodule

FILE: sim/i2c_master_transaction_sequencer_tb.sv
// Self-checking testbench for the I2C master transaction sequencer.
module i2c_master_transaction_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int PAYLOAD_DEPTH = 32;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 40;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_TX, SEQ_RX} seq_phase_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // Shadow of the sequencer state, advanced as each request is accepted.
    seq_phase_t  seq_phase;
    logic        read_queued;
    logic [7:0]  payload [PAYLOAD_DEPTH];
    bit          payload_set [PAYLOAD_DEPTH];
    int          byte_pos;
    int          xfer_len;
    int          rx_len;
    logic [7:0]  status_q;
    logic        err_q;
    logic [6:0]  dev_q;
    logic [7:0]  reg_q;
    logic [2:0]  last_action;
    logic [7:0]  last_code;
    int          rx_overrun;

    result_t     expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int transfer_count = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    i2c_master_transaction_sequencer #(
        .BUFFER_DEPTH(PAYLOAD_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void queue_result(logic [2:0] act, logic [7:0] tx, logic [7:0] rd,
                                         logic fin);
        result_t r;
        r.action      = act;
        r.tx_byte     = tx;
        r.read_byte   = rd;
        r.busy_res    = (seq_phase != SEQ_IDLE);
        r.error       = err_q;
        r.status_code = status_q;
        r.last        = fin;
        expected_results.push_back(r);
        last_action = act;
    endfunction

    function automatic logic [7:0] byte_at(int pos);
        if (seq_phase == SEQ_RX)
            return {dev_q, 1'b1};
        if (pos == 0)
            return {dev_q, 1'b0};
        if (pos == 1)
            return reg_q;
        if (pos - 2 < PAYLOAD_DEPTH)
            return payload[pos - 2];
        return 8'h00;
    endfunction

    function automatic void capture_byte(logic [7:0] d);
        if (byte_pos < PAYLOAD_DEPTH)
        begin
            payload[byte_pos]     = d;
            payload_set[byte_pos] = 1'b1;
        end
    endfunction

    // A stop ends the phase; a read whose address phase is done turns
    // around into receive mode with a fresh start.
    function automatic void end_transfer();
        if (read_queued)
        begin
            read_queued = 1'b0;
            seq_phase   = SEQ_RX;
            byte_pos    = 0;
            xfer_len    = rx_len;
            queue_result(ACT_STOP, 8'h00, 8'h00, 1'b0);
            queue_result(ACT_START, 8'h00, 8'h00, 1'b1);
        end
        else
        begin
            seq_phase = SEQ_IDLE;
            queue_result(ACT_STOP, 8'h00, 8'h00, 1'b1);
        end
    endfunction

    function automatic void predict_request(item_t it);
        int         len;
        logic [7:0] b;
        logic [7:0] code;
        len  = (it.length > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(it.length);
        code = it.bus_code;
        case (it.kind)
            KIND_LOAD:
            begin
                if (seq_phase == SEQ_IDLE)
                begin
                    payload[it.buffer_index]     = it.data_byte;
                    payload_set[it.buffer_index] = 1'b1;
                end
                queue_result(ACT_NONE, 8'h00, 8'h00, 1'b1);
            end
            KIND_FETCH:
                queue_result(ACT_NONE, 8'h00, payload[it.buffer_index], 1'b1);
            KIND_START:
            begin
                if (seq_phase != SEQ_IDLE || it.op > OP_PING)
                    queue_result(ACT_NONE, 8'h00, 8'h00, 1'b1);
                else
                begin
                    dev_q       = it.device_id;
                    reg_q       = it.register_addr;
                    byte_pos    = 0;
                    seq_phase   = SEQ_TX;
                    read_queued = 1'b0;
                    if (it.op == OP_WRITE)
                        xfer_len = len + 2;
                    else if (it.op == OP_READ)
                    begin
                        xfer_len    = 2;
                        rx_len      = len;
                        read_queued = 1'b1;
                    end
                    else
                        xfer_len = 1;
                    queue_result(ACT_START, 8'h00, 8'h00, 1'b1);
                end
            end
            default:
            begin
                last_code = code;
                if (seq_phase == SEQ_IDLE)
                    queue_result(ACT_NONE, 8'h00, 8'h00, 1'b1);
                else if (code == BUS_START || code == BUS_RESTART)
                begin
                    byte_pos = 0;
                    status_q = STATUS_OK;
                    err_q    = 1'b0;
                    queue_result(ACT_NACK, byte_at(0), 8'h00, 1'b1);
                end
                else if (seq_phase == SEQ_TX && (code == BUS_ADDR_W_ACK || code == BUS_DATA_TX))
                begin
                    if (code == BUS_ADDR_W_ACK)
                        byte_pos++;
                    if (byte_pos < xfer_len)
                    begin
                        b = byte_at(byte_pos);
                        byte_pos++;
                        queue_result(ACT_NACK, b, 8'h00, 1'b1);
                    end
                    else
                    begin
                        status_q = STATUS_OK;
                        err_q    = 1'b0;
                        end_transfer();
                    end
                end
                else if (seq_phase == SEQ_RX && (code == BUS_ADDR_R_ACK || code == BUS_DATA_ACK))
                begin
                    if (code == BUS_DATA_ACK)
                    begin
                        capture_byte(it.data_byte);
                        if (byte_pos < PAYLOAD_DEPTH)
                            byte_pos++;
                    end
                    queue_result((byte_pos + 1 < rx_len && rx_len != 0) ? ACT_ACK : ACT_NACK,
                                 8'h00, 8'h00, 1'b1);
                end
                else if (seq_phase == SEQ_RX && code == BUS_DATA_NACK)
                begin
                    capture_byte(it.data_byte);
                    status_q = STATUS_OK;
                    err_q    = 1'b0;
                    end_transfer();
                end
                else
                begin
                    status_q = code;
                    err_q    = 1'b1;
                    end_transfer();
                end
            end
        endcase
    endfunction

    // Count of payload entries written from index zero without a hole.
    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < PAYLOAD_DEPTH && payload_set[n])
            n++;
        return n;
    endfunction

    // The code a healthy bus engine would report next.
    function automatic logic [7:0] next_bus_code();
        if (last_action == ACT_START)
            return ($urandom_range(0, 1) != 0) ? BUS_START : BUS_RESTART;
        if (seq_phase == SEQ_TX)
            return (byte_pos == 0) ? BUS_ADDR_W_ACK : BUS_DATA_TX;
        if (last_code == BUS_START || last_code == BUS_RESTART)
            return BUS_ADDR_R_ACK;
        if (byte_pos + 1 < rx_len)
            return BUS_DATA_ACK;
        if (rx_overrun > 0)
        begin
            rx_overrun--;
            return BUS_DATA_ACK;
        end
        return BUS_DATA_NACK;
    endfunction

    function automatic item_t random_item();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[45:0];
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Returns right after the accepting edge; valid is left as it is so the
    // next call or a drain decides its level at the following falling edge.
    task automatic send_request(input item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {4'h0, it.bus_code, it.data_byte, it.buffer_index, it.length,
                     it.register_addr, it.device_id, it.op};
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(it);
        sent_count++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic load_byte(input logic [4:0] idx, input logic [7:0] val);
        item_t it;
        it              = random_item();
        it.kind         = KIND_LOAD;
        it.buffer_index = idx;
        it.data_byte    = val;
        send_request(it);
    endtask

    task automatic fetch_byte(input logic [4:0] idx);
        item_t it;
        it              = random_item();
        it.kind         = KIND_FETCH;
        it.buffer_index = idx;
        send_request(it);
    endtask

    task automatic start_request(input logic [1:0] op, input logic [6:0] dev,
                                 input logic [7:0] rg, input logic [5:0] len);
        item_t it;
        it               = random_item();
        it.kind          = KIND_START;
        it.op            = op;
        it.device_id     = dev;
        it.register_addr = rg;
        it.length        = len;
        send_request(it);
    endtask

    task automatic bus_event(input logic [7:0] code, input logic [7:0] data);
        item_t it;
        it           = random_item();
        it.kind      = KIND_EVENT;
        it.bus_code  = code;
        it.data_byte = data;
        send_request(it);
    endtask

    // One whole transaction: payload loads for a write, the start, then bus
    // events until the sequencer is idle. A corrupted step injects any code.
    task automatic run_transfer(input logic [1:0] op, input logic [5:0] len,
                                input int overrun, input int corrupt_at);
        int         steps;
        int         n;
        logic [7:0] code;
        n = (len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(len);
        if (op == OP_WRITE)
            for (int i = 0; i < n; i++)
                load_byte(i[4:0], 8'($urandom_range(0, 255)));
        rx_overrun = overrun;
        start_request(op, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), len);
        steps = 0;
        while (seq_phase != SEQ_IDLE && steps < 80)
        begin
            code = next_bus_code();
            if (steps == corrupt_at)
                code = 8'($urandom_range(0, 255));
            bus_event(code, 8'($urandom_range(0, 255)));
            steps++;
        end
        // 0xF8 is never expected, so it forces the transfer to end.
        while (seq_phase != SEQ_IDLE)
            bus_event(8'hF8, 8'h00);
        transfer_count++;
    endtask

    task automatic send_noise();
        item_t it;
        int    room;
        it = random_item();
        if (it.kind == KIND_START && it.op == OP_WRITE)
        begin
            room = loaded_prefix();
            if (((it.length > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(it.length)) > room)
                it.length = 6'($urandom_range(0, room));
        end
        // Never fetch an entry that nothing has written yet.
        if (it.kind == KIND_FETCH && !payload_set[it.buffer_index])
            it.kind = KIND_LOAD;
        send_request(it);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                     checked_count, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending", int'(m_tdata), 0);
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[2:0] !== want.action)
                    report_mismatch("action", int'(m_tdata[2:0]), int'(want.action));
                if (m_tdata[10:3] !== want.tx_byte)
                    report_mismatch("tx_byte", int'(m_tdata[10:3]), int'(want.tx_byte));
                if (m_tdata[18:11] !== want.read_byte)
                    report_mismatch("read_byte", int'(m_tdata[18:11]), int'(want.read_byte));
                if (m_tdata[19] !== want.busy_res)
                    report_mismatch("busy_res", int'(m_tdata[19]), int'(want.busy_res));
                if (m_tdata[20] !== want.error)
                    report_mismatch("error", int'(m_tdata[20]), int'(want.error));
                if (m_tdata[28:21] !== want.status_code)
                    report_mismatch("status_code", int'(m_tdata[28:21]),
                                    int'(want.status_code));
                if (m_tlast !== want.last)
                    report_mismatch("last", int'(m_tlast), int'(want.last));
            end
            checked_count++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no request or result moved for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_buffer_access();
        load_byte(5'd0, 8'h00);
        load_byte(5'd31, 8'hFF);
        fetch_byte(5'd0);
        fetch_byte(5'd31);
        wait_for_drain();
    endtask

    task automatic test_ping_and_ignores();
        bus_event(BUS_DATA_TX, 8'hFF);                 // event while idle
        start_request(2'd3, 7'h7F, 8'hFF, 6'h3F);      // unknown op
        start_request(OP_PING, 7'h7F, 8'hFF, 6'd0);
        bus_event(BUS_START, 8'h00);
        bus_event(BUS_ADDR_W_ACK, 8'h00);
        wait_for_drain();
    endtask

    task automatic test_write_transfer();
        start_request(OP_WRITE, 7'h00, 8'h00, 6'd1);
        bus_event(BUS_RESTART, 8'h00);
        start_request(OP_READ, 7'h12, 8'h34, 6'd4);    // start while busy
        load_byte(5'd0, 8'h77);                        // load while busy
        bus_event(BUS_ADDR_W_ACK, 8'h00);
        bus_event(BUS_DATA_TX, 8'h00);
        bus_event(BUS_DATA_TX, 8'h00);
        transfer_count++;
        wait_for_drain();
    endtask

    task automatic test_read_transfer();
        // Zero receive length: the single byte is taken without an ack.
        start_request(OP_READ, 7'h55, 8'h80, 6'd0);
        bus_event(BUS_START, 8'h00);
        bus_event(BUS_ADDR_W_ACK, 8'h00);
        bus_event(BUS_DATA_TX, 8'h00);
        bus_event(BUS_START, 8'h00);
        bus_event(BUS_ADDR_R_ACK, 8'h00);
        bus_event(BUS_DATA_NACK, 8'hC3);
        fetch_byte(5'd0);
        transfer_count++;
        wait_for_drain();
    endtask

    task automatic test_bus_errors();
        start_request(OP_WRITE, 7'h2A, 8'h01, 6'd1);
        bus_event(BUS_START, 8'h00);
        bus_event(BUS_DATA_NACK, 8'h00);               // receive code while sending
        // A failed address phase of a read still turns around.
        start_request(OP_READ, 7'h01, 8'hFE, 6'd2);
        bus_event(8'h00, 8'h00);
        bus_event(BUS_RESTART, 8'h00);
        bus_event(BUS_ADDR_R_ACK, 8'h00);
        bus_event(BUS_DATA_TX, 8'h00);                 // send code while receiving
        transfer_count += 2;
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
        int         stop_at;
        logic [1:0] op;
        logic [5:0] len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = sent_count + n;
        while (sent_count < stop_at)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                op  = 2'($urandom_range(0, 2));
                len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 5));
                run_transfer(op, len, ($urandom_range(0, 3) == 0) ? 2 : 0,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : -1);
            end
            else
                send_noise();
        end
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // The receiver holds off while a long read is fed in, so the result
        // queue fills and the sequencer stops taking requests.
        hold_cycles = 300;
        run_transfer(OP_READ, 6'd40, 3, -1);
        wait_for_drain();
        run_transfer(OP_WRITE, 6'd45, 0, -1);
        wait_for_drain();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;

        seq_phase   = SEQ_IDLE;
        read_queued = 1'b0;
        byte_pos    = 0;
        xfer_len    = 0;
        rx_len      = 0;
        status_q    = STATUS_OK;
        err_q       = 1'b0;
        dev_q       = '0;
        reg_q       = '0;
        last_action = ACT_NONE;
        last_code   = '0;
        rx_overrun  = 0;
        for (int i = 0; i < PAYLOAD_DEPTH; i++)
        begin
            payload[i]     = '0;
            payload_set[i] = 1'b0;
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_buffer_access();
        test_ping_and_ignores();
        test_write_transfer();
        test_read_transfer();
        test_bus_errors();
        test_random_traffic(19, 67, 85);
        test_random_traffic(67, 19, 85);
        test_random_traffic(0, 0, 85);
        test_backpressure();

        wait_for_drain();
        repeat (16) @(posedge clk);
        $display("Covered %0d requests and %0d checked results over %0d transactions,",
                 sent_count, checked_count, transfer_count);
        $display("with idle mixes on both sides and a long receiver hold-off.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/i2cms_pkg.sv
rtl/i2cms_store.sv
rtl/i2cms_fsm.sv
rtl/i2cms_out_fifo.sv
rtl/i2c_master_transaction_sequencer.sv
sim/i2c_master_transaction_sequencer_tb.sv
